### rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared constants for the bitmap page frame allocator: map geometry,
// counter widths, request codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int L0_DEPTH   = MAX_FRAMES / WORD_W;
  localparam int L0_AW      = $clog2(L0_DEPTH);
  localparam int L1_DEPTH   = L0_DEPTH / WORD_W;
  localparam int L1_AW      = $clog2(L1_DEPTH);

  localparam int CNT_W      = 17;
  localparam int IN_FRAME_W = 20;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [CNT_W-1:0] MAX_FRAMES_C   = CNT_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0] RESET_TOTAL    = CNT_W'(65536);
  localparam logic [CNT_W-1:0] RESET_RESERVED = CNT_W'(512);

  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_USE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd1;

endpackage

`default_nettype wire

### rtl/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// One used/free bit per page frame, kept in a RAM of 64-bit words with a
// summary RAM and a small summary register for fast lowest-free search.
//
// Request channel: func_i/frame_i are taken at a clock edge where start is
// high and busy is low. Each request gives one item on the result ports,
// marked by done_o for exactly one cycle; the receiver cannot stall.
// Each request walks read-modify-write passes over the map RAM and the
// summary RAM. A mark that changes a bit reads the map word, writes it
// back, then writes the summary word; a mark with nothing to do (out of
// range, or bit already so) writes nothing. An allocate searches the floor
// word, the summary word and the summary register, reads the chosen map
// word, sets the bit and writes the summary word, or ends with no frame.
// A new request is taken in the cycle done_o is shown.
// Reset: all frames marked used, free count zero. A clearing pass then
// fills every one of the L0_DEPTH (1024) map words with ones; busy stays
// high until it ends. Configuration writes (cfg_we_i) are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_frame_allocator
  import bpfa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CNT_W-1:0]      cfg_data_i,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FUNC_W-1:0]     func_i,
  input  wire logic [IN_FRAME_W-1:0] frame_i,
  output logic                       done_o,
  output logic [FRAME_W-1:0]         result_frame_o,
  output logic                       ok_o,
  output logic [CNT_W-1:0]           used_frames_o,
  output logic [CNT_W-1:0]           free_frames_o
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MRD, S_A0, S_A1, S_A2, S_AW, S_SUM
  } state_e;

  localparam int B2 = 2 * BIT_W;

  function automatic logic [BIT_W-1:0] ffs_word(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [L1_AW-1:0] ffs_top(input logic [L1_DEPTH-1:0] v);
    logic [L1_AW-1:0] r;
    r = '0;
    for (int i = L1_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = L1_AW'(i);
    end
    return r;
  endfunction

  state_e               state_q;
  logic [L0_AW-1:0]     cnt_q;
  logic [CNT_W-1:0]     total_q, reserved_q;
  logic [FUNC_W-1:0]    func_q;
  logic [FRAME_W-1:0]   tgt_q;
  logic [CNT_W-1:0]     lo_q, tot_q;
  logic [WORD_W-1:0]    word_q;
  logic                 hz_q;
  logic [L1_DEPTH-1:0]  l2_q;
  logic [CNT_W-1:0]     free_count_q;
  logic                 done_q, ok_q;
  logic [FRAME_W-1:0]   result_q;

  logic                 l0_en, l0_we, l1_en, l1_we;
  logic [L0_AW-1:0]     l0_addr;
  logic [L1_AW-1:0]     l1_addr;
  logic [WORD_W-1:0]    l0_wdata, l1_wdata, l0_rdata, l1_rdata;

  logic [CNT_W-1:0]     tot_eff;
  logic                 accept, in_range, alloc_go;
  logic [WORD_W-1:0]    cand0, m1, l1_src, bit_mask, sum_mask, mark_word, l1_new;
  logic [L1_DEPTH-1:0]  m2;
  logic [L1_AW-1:0]     l1_hi;
  logic [FRAME_W-BIT_W-1:0] w_sel;
  logic                 change, hz_d;
  logic [CNT_W-1:0]     fc_d;

  assign tot_eff  = (total_q > MAX_FRAMES_C) ? MAX_FRAMES_C : total_q;
  assign accept   = start && !busy;
  assign in_range = frame_i < IN_FRAME_W'(tot_eff);
  assign alloc_go = reserved_q < tot_eff;

  assign cand0    = ~l0_rdata & ({WORD_W{1'b1}} << lo_q[BIT_W-1:0]);
  assign m1       = l1_rdata & (({WORD_W{1'b1}} << lo_q[B2-1:BIT_W]) << 1);
  assign m2       = l2_q & (({L1_DEPTH{1'b1}} << lo_q[FRAME_W-1:B2]) << 1);
  assign l1_src   = (state_q == S_A0) ? m1 : l1_rdata;
  assign l1_hi    = (state_q == S_A0) ? lo_q[FRAME_W-1:B2] : tgt_q[FRAME_W-1:B2];
  assign w_sel    = {l1_hi, ffs_word(l1_src)};

  assign bit_mask  = WORD_W'(1) << tgt_q[BIT_W-1:0];
  assign sum_mask  = WORD_W'(1) << tgt_q[B2-1:BIT_W];
  assign change    = l0_rdata[tgt_q[BIT_W-1:0]] == (func_q == FUNC_FREE);
  assign mark_word = (func_q == FUNC_FREE) ? (l0_rdata & ~bit_mask) : (l0_rdata | bit_mask);
  assign hz_d      = ~&l0_wdata;
  assign l1_new    = hz_q ? (l1_rdata | sum_mask) : (l1_rdata & ~sum_mask);

  always_comb begin
    fc_d = free_count_q;
    if (func_q == FUNC_FREE) begin
      if (free_count_q != CNT_MAX) fc_d = free_count_q + CNT_W'(1);
    end else if (free_count_q != '0) begin
      fc_d = free_count_q - CNT_W'(1);
    end
  end

  always_comb begin
    l0_en    = 1'b0;
    l0_we    = 1'b0;
    l0_addr  = '0;
    l0_wdata = '0;
    l1_en    = 1'b0;
    l1_we    = 1'b0;
    l1_addr  = '0;
    l1_wdata = '0;
    unique case (state_q)
      S_CLR: begin
        l0_en    = 1'b1;
        l0_we    = 1'b1;
        l0_addr  = cnt_q;
        l0_wdata = '1;
        l1_en    = 1'b1;
        l1_we    = 1'b1;
        l1_addr  = cnt_q[L1_AW-1:0];
      end
      S_IDLE: begin
        if (accept && (func_i == FUNC_FREE || func_i == FUNC_USE) && in_range) begin
          l0_en   = 1'b1;
          l0_addr = frame_i[FRAME_W-1:BIT_W];
        end else if (accept && func_i == FUNC_ALLOC && alloc_go) begin
          l0_en   = 1'b1;
          l0_addr = reserved_q[FRAME_W-1:BIT_W];
          l1_en   = 1'b1;
          l1_addr = reserved_q[FRAME_W-1:B2];
        end
      end
      S_MRD: begin
        l0_wdata = mark_word;
        if (change) begin
          l0_en   = 1'b1;
          l0_we   = 1'b1;
          l0_addr = tgt_q[FRAME_W-1:BIT_W];
          l1_en   = 1'b1;
          l1_addr = tgt_q[FRAME_W-1:B2];
        end
      end
      S_A0: begin
        if (cand0 == '0 && m1 != '0) begin
          l0_en   = 1'b1;
          l0_addr = w_sel;
        end else if (cand0 == '0 && m2 != '0) begin
          l1_en   = 1'b1;
          l1_addr = ffs_top(m2);
        end
      end
      S_A1: begin
        l0_en   = 1'b1;
        l0_addr = w_sel;
      end
      S_A2: begin
      end
      S_AW: begin
        l0_wdata = word_q | bit_mask;
        if (CNT_W'(tgt_q) < tot_q) begin
          l0_en   = 1'b1;
          l0_we   = 1'b1;
          l0_addr = tgt_q[FRAME_W-1:BIT_W];
          l1_en   = 1'b1;
          l1_addr = tgt_q[FRAME_W-1:B2];
        end
      end
      S_SUM: begin
        l1_en    = 1'b1;
        l1_we    = 1'b1;
        l1_addr  = tgt_q[FRAME_W-1:B2];
        l1_wdata = l1_new;
      end
    endcase
  end

  bpfa_ram #(.Width(WORD_W), .Depth(L0_DEPTH)) u_map (
    .clk_i   (clk_i),
    .en_i    (l0_en),
    .we_i    (l0_we),
    .addr_i  (l0_addr),
    .wdata_i (l0_wdata),
    .rdata_o (l0_rdata)
  );

  bpfa_ram #(.Width(WORD_W), .Depth(L1_DEPTH)) u_sum (
    .clk_i   (clk_i),
    .en_i    (l1_en),
    .we_i    (l1_we),
    .addr_i  (l1_addr),
    .wdata_i (l1_wdata),
    .rdata_o (l1_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      cnt_q        <= '0;
      total_q      <= RESET_TOTAL;
      reserved_q   <= RESET_RESERVED;
      func_q       <= '0;
      tgt_q        <= '0;
      lo_q         <= '0;
      tot_q        <= '0;
      word_q       <= '0;
      hz_q         <= 1'b0;
      l2_q         <= '0;
      free_count_q <= '0;
      done_q       <= 1'b0;
      ok_q         <= 1'b0;
      result_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL:    total_q    <= cfg_data_i;
          CFG_RESERVED: reserved_q <= cfg_data_i;
        endcase
      end
      unique case (state_q)
        S_CLR: begin
          cnt_q <= cnt_q + L0_AW'(1);
          if (cnt_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            func_q <= func_i;
            tgt_q  <= frame_i[FRAME_W-1:0];
            lo_q   <= reserved_q;
            tot_q  <= tot_eff;
            priority if ((func_i == FUNC_FREE || func_i == FUNC_USE) && in_range) begin
              state_q <= S_MRD;
            end else if (func_i == FUNC_ALLOC && alloc_go) begin
              state_q <= S_A0;
            end else begin
              done_q   <= 1'b1;
              ok_q     <= 1'b0;
              result_q <= '0;
            end
          end
        end
        S_MRD: begin
          if (change) begin
            hz_q    <= hz_d;
            state_q <= S_SUM;
          end else begin
            done_q   <= 1'b1;
            ok_q     <= 1'b0;
            result_q <= '0;
            state_q  <= S_IDLE;
          end
        end
        S_A0: begin
          priority if (cand0 != '0) begin
            tgt_q   <= {lo_q[FRAME_W-1:BIT_W], ffs_word(cand0)};
            word_q  <= l0_rdata;
            state_q <= S_AW;
          end else if (m1 != '0) begin
            tgt_q[FRAME_W-1:BIT_W] <= w_sel;
            state_q <= S_A2;
          end else if (m2 != '0) begin
            tgt_q[FRAME_W-1:B2] <= ffs_top(m2);
            state_q <= S_A1;
          end else begin
            done_q   <= 1'b1;
            ok_q     <= 1'b0;
            result_q <= '0;
            state_q  <= S_IDLE;
          end
        end
        S_A1: begin
          tgt_q[FRAME_W-1:BIT_W] <= w_sel;
          state_q <= S_A2;
        end
        S_A2: begin
          tgt_q[BIT_W-1:0] <= ffs_word(~l0_rdata);
          word_q  <= l0_rdata;
          state_q <= S_AW;
        end
        S_AW: begin
          if (CNT_W'(tgt_q) < tot_q) begin
            hz_q    <= hz_d;
            state_q <= S_SUM;
          end else begin
            done_q   <= 1'b1;
            ok_q     <= 1'b0;
            result_q <= '0;
            state_q  <= S_IDLE;
          end
        end
        S_SUM: begin
          l2_q[tgt_q[FRAME_W-1:B2]] <= |l1_new;
          free_count_q <= fc_d;
          done_q   <= 1'b1;
          ok_q     <= 1'b1;
          result_q <= (func_q == FUNC_ALLOC) ? tgt_q : '0;
          state_q  <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = state_q != S_IDLE;
  assign done_o         = done_q;
  assign ok_o           = ok_q;
  assign result_frame_o = result_q;
  assign free_frames_o  = free_count_q;
  assign used_frames_o  = (tot_q > free_count_q) ? (tot_q - free_count_q) : '0;

endmodule

`default_nettype wire

### rtl/bpfa_checker.sv
// ----------------------------------------------------------------------------
// bpfa_port_checker
// Port-level checks for the bitmap page frame allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_port_checker
  import bpfa_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done_o,
  input wire logic [FRAME_W-1:0]    result_frame_o,
  input wire logic                  ok_o,
  input wire logic [CNT_W-1:0]      used_frames_o,
  input wire logic [CNT_W-1:0]      free_frames_o
);

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted item neither in progress nor done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> result_frame_o == '0)
    else $error("failed item carries a frame");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> free_frames_o <= MAX_FRAMES_C && used_frames_o <= MAX_FRAMES_C)
    else $error("frame count out of range");

endmodule

bind bitmap_page_frame_allocator bpfa_port_checker u_bpfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .result_frame_o (result_frame_o),
  .ok_o           (ok_o),
  .used_frames_o  (used_frames_o),
  .free_frames_o  (free_frames_o)
);

`default_nettype wire

### dv/bpfa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpfa_checker
// Passive checker for the bitmap page frame allocator. Tracks register
// writes and accepted requests, keeps its own frame map and free count,
// predicts the result of every item and compares each done_o strobe with
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module bpfa_checker
  import bpfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CNT_W-1:0]      cfg_data_i,
  input  logic                  start,
  input  logic                  busy,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [IN_FRAME_W-1:0] frame_i,
  input  logic                  done_o,
  input  logic [FRAME_W-1:0]    result_frame_o,
  input  logic                  ok_o,
  input  logic [CNT_W-1:0]      used_frames_o,
  input  logic [CNT_W-1:0]      free_frames_o,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    grants_o
);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               ok;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   free;
  } frame_result_t;

  logic [WORD_W-1:0] frame_words [L0_DEPTH];
  logic [CNT_W-1:0]  free_tally;
  logic [CNT_W-1:0]  total_cfg;
  logic [CNT_W-1:0]  floor_cfg;
  frame_result_t     expected_q [$];
  int                mismatches = 0;
  int                checked = 0;
  int                grants = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    grants_o     = 0;
  end

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH result %0d %s: expected %0d, got %0d", checked, field, want, got);
    mismatches++;
  endtask

  function automatic frame_result_t apply_request(logic [FUNC_W-1:0] op,
                                                  logic [IN_FRAME_W-1:0] frm);
    frame_result_t    r;
    logic [CNT_W-1:0] lim;
    int               f;
    r   = '0;
    lim = (total_cfg > MAX_FRAMES_C) ? MAX_FRAMES_C : total_cfg;
    case (op)
      FUNC_FREE: begin
        if (frm < lim && frame_words[frm[FRAME_W-1:BIT_W]][frm[BIT_W-1:0]]) begin
          frame_words[frm[FRAME_W-1:BIT_W]][frm[BIT_W-1:0]] = 1'b0;
          if (free_tally != CNT_MAX) free_tally = free_tally + 1'b1;
          r.ok = 1'b1;
        end
      end
      FUNC_USE: begin
        if (frm < lim && !frame_words[frm[FRAME_W-1:BIT_W]][frm[BIT_W-1:0]]) begin
          frame_words[frm[FRAME_W-1:BIT_W]][frm[BIT_W-1:0]] = 1'b1;
          if (free_tally != '0) free_tally = free_tally - 1'b1;
          r.ok = 1'b1;
        end
      end
      FUNC_ALLOC: begin
        f = int'(floor_cfg);
        while (f < int'(lim) && !r.ok) begin
          if (&frame_words[f >> BIT_W]) begin
            f = (f | (WORD_W - 1)) + 1;
          end else if (!frame_words[f >> BIT_W][f % WORD_W]) begin
            frame_words[f >> BIT_W][f % WORD_W] = 1'b1;
            if (free_tally != '0) free_tally = free_tally - 1'b1;
            r.frame = f[FRAME_W-1:0];
            r.ok    = 1'b1;
          end else begin
            f++;
          end
        end
      end
      default: begin
      end
    endcase
    r.used = (lim > free_tally) ? lim - free_tally : '0;
    r.free = free_tally;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < L0_DEPTH; i++) frame_words[i] = '1;
      free_tally = '0;
      total_cfg  = RESET_TOTAL;
      floor_cfg  = RESET_RESERVED;
      expected_q.delete();
    end else begin
      if (done_o) begin
        checked++;
        if (expected_q.size() == 0) begin
          report_mismatch("arrived with no item outstanding", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (result_frame_o !== want.frame)
            report_mismatch("result_frame", want.frame, result_frame_o);
          if (ok_o !== want.ok) report_mismatch("ok", want.ok, ok_o);
          if (used_frames_o !== want.used)
            report_mismatch("used_frames", want.used, used_frames_o);
          if (free_frames_o !== want.free)
            report_mismatch("free_frames", want.free, free_frames_o);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TOTAL) total_cfg = cfg_data_i;
        else if (cfg_idx_i == CFG_RESERVED) floor_cfg = cfg_data_i;
      end
      if (start && !busy) begin
        want = apply_request(func_i, frame_i);
        if (func_i == FUNC_ALLOC && want.ok) grants++;
        expected_q.push_back(want);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
    grants_o     <= grants;
  end

endmodule

### dv/tb_bitmap_page_frame_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_frame_allocator
// Drives requests and register writes into the allocator: a directed run at
// the reset settings, then random marks, allocations and free-then-allocate
// runs over a series of totals and reserved floors, with random hold-offs.
// Checking is done by bpfa_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bitmap_page_frame_allocator;
  import bpfa_pkg::*;

  localparam int                LIMIT_CYCLES = 200000;
  localparam int                PHASES       = 10;
  localparam int                DIRECTED     = 24;
  localparam int                QUIET_TAIL   = 150;
  localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_TOTAL;
  logic [CNT_W-1:0]      cfg_data_i = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     func_i = FUNC_FREE;
  logic [IN_FRAME_W-1:0] frame_i = '0;
  logic                  done_o;
  logic [FRAME_W-1:0]    result_frame_o;
  logic                  ok_o;
  logic [CNT_W-1:0]      used_frames_o;
  logic [CNT_W-1:0]      free_frames_o;

  int fail_count, pending, checked, grants;
  int cycles = 0;
  int items_sent = 0;
  int planned_items = DIRECTED;

  logic [CNT_W-1:0] total_set = RESET_TOTAL;
  logic [CNT_W-1:0] floor_set = RESET_RESERVED;

  int total_tab [PHASES] = '{65536, 0, 131071, 131071, 64, 200, 1000, 300, 8, 65536};
  int floor_tab [PHASES] = '{512, 0, 65536, 131071, 0, 100, 5, 5, 7, 0};
  int count_tab [PHASES] = '{150, 40, 40, 40, 330, 300, 250, 250, 150, 250};

  logic [FUNC_W-1:0]     dir_op [DIRECTED] = '{
    FUNC_ALLOC, FUNC_USE, FUNC_FREE, FUNC_FREE, FUNC_FREE, FUNC_FREE, FUNC_FREE, FUNC_FREE,
    FUNC_FREE, FUNC_FREE, FUNC_NONE, FUNC_ALLOC, FUNC_ALLOC, FUNC_ALLOC, FUNC_ALLOC,
    FUNC_USE, FUNC_USE, FUNC_USE, FUNC_NONE, FUNC_USE, FUNC_FREE, FUNC_FREE, FUNC_FREE,
    FUNC_ALLOC};
  logic [IN_FRAME_W-1:0] dir_frame [DIRECTED] = '{
    20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h001FF, 20'h00200, 20'h00201,
    20'h0FFFF, 20'h10000, 20'hFFFFF, 20'h00005, 20'hFFFFF, 20'h00000, 20'h12345,
    20'h00000, 20'h00000, 20'h00000, 20'h001FF, 20'hFFFFF, 20'hFFFFF, 20'h80000,
    20'h00040, 20'h00258, 20'h00000};

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  bitmap_page_frame_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .frame_i        (frame_i),
    .done_o         (done_o),
    .result_frame_o (result_frame_o),
    .ok_o           (ok_o),
    .used_frames_o  (used_frames_o),
    .free_frames_o  (free_frames_o)
  );

  bpfa_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .frame_i        (frame_i),
    .done_o         (done_o),
    .result_frame_o (result_frame_o),
    .ok_o           (ok_o),
    .used_frames_o  (used_frames_o),
    .free_frames_o  (free_frames_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .grants_o       (grants)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("bitmap_page_frame_allocator verification failed");
      $finish;
    end
  end

  // hold start high on return; the next item or a hold-off decides what follows
  task automatic send_item(logic [FUNC_W-1:0] op, logic [IN_FRAME_W-1:0] frm);
    @(negedge clk_i);
    start   <= 1'b1;
    func_i  <= op;
    frame_i <= frm;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic maybe_idle();
    int n;
    if (items_sent + QUIET_TAIL < planned_items && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_TOTAL) total_set = data;
    else floor_set = data;
  endtask

  function automatic logic [FUNC_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return FUNC_FREE;
    if (r < 72) return FUNC_ALLOC;
    if (r < 94) return FUNC_USE;
    return FUNC_NONE;
  endfunction

  // bias toward the allocation floor, the low frames and the total boundary
  function automatic logic [IN_FRAME_W-1:0] pick_frame();
    int eff, span, base, r;
    eff  = (total_set > MAX_FRAMES_C) ? MAX_FRAMES : int'(total_set);
    span = (eff + 4 < 256) ? eff + 4 : 256;
    base = (int'(floor_set) < eff) ? int'(floor_set) : 0;
    r    = $urandom_range(0, 99);
    if (r < 40) return IN_FRAME_W'(base + $urandom_range(0, span - 1));
    if (r < 55) return IN_FRAME_W'($urandom_range(0, span - 1));
    if (r < 70) return IN_FRAME_W'(eff + $urandom_range(0, 8) - 4);
    if (r < 80) return IN_FRAME_W'($urandom);
    return IN_FRAME_W'($urandom_range(0, (eff > 0) ? eff - 1 : 0));
  endfunction

  initial begin
    int                    remaining;
    int                    k;
    logic [IN_FRAME_W-1:0] base;
    for (int p = 0; p < PHASES; p++) planned_items += count_tab[p];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_TOTAL, CNT_W'(total_tab[p]));
      write_reg(CFG_RESERVED, CNT_W'(floor_tab[p]));
      if (p == 0) begin
        for (int i = 0; i < DIRECTED; i++) begin
          maybe_idle();
          send_item(dir_op[i], dir_frame[i]);
        end
      end
      remaining = count_tab[p];
      while (remaining > 0) begin
        if (remaining > 13 && $urandom_range(0, 99) < 15) begin
          // free a short run, then allocate one more than was freed
          k    = $urandom_range(1, 6);
          base = pick_frame();
          for (int j = 0; j < k; j++) begin
            maybe_idle();
            send_item(FUNC_FREE, base + IN_FRAME_W'(j));
          end
          for (int j = 0; j <= k; j++) begin
            maybe_idle();
            send_item(FUNC_ALLOC, IN_FRAME_W'($urandom));
          end
          remaining -= 2 * k + 1;
        end else begin
          maybe_idle();
          send_item(pick_op(), pick_frame());
          remaining--;
        end
      end
    end
    drain();

    $display("Sent %0d items over %0d register settings, totals 0 to 131071 and floors 0 to 131071",
             items_sent, PHASES);
    $display("Checked %0d results, %0d allocations granted", checked, grants);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("bitmap_page_frame_allocator verification clean");
    end else begin
      $display("bitmap_page_frame_allocator verification failed");
    end
    $finish;
  end

endmodule
